@@ src/dtfc_pkg.sv @@
// Shared types, constants and duty arithmetic for the four-channel PWM drive.
`timescale 1ns / 1ps
`default_nettype none

package dtfc_pkg;

  localparam int unsigned DUTY_W = 8;
  localparam int unsigned DIR_W  = 8;
  localparam int unsigned NUM_DIRS = 16;

  localparam logic [DUTY_W-1:0] PERIOD_TOP_RESET = 8'd100;
  localparam logic [DIR_W-1:0]  DIR_STATIONARY   = 8'd31;

  // Light bits: head, tail, right indicator, left indicator.
  localparam logic [3:0] L_NONE = 4'b0000;
  localparam logic [3:0] L_HEAD = 4'b0001;
  localparam logic [3:0] L_TAIL = 4'b0010;
  localparam logic [3:0] L_RIND = 4'b0100;
  localparam logic [3:0] L_LIND = 4'b1000;

  // Beat kinds.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  typedef enum logic [2:0] {
    T_ZERO   = 3'd0,
    T_FULL   = 3'd1,
    T_HALF   = 3'd2,
    T_THIRD  = 3'd3,
    T_DOUBLE = 3'd4,
    T_FIFTH  = 3'd5
  } term_sel_t;

  typedef struct packed {
    term_sel_t  lf;
    term_sel_t  lr;
    term_sel_t  rf;
    term_sel_t  rr;
    logic [3:0] lights;
  } dir_entry_t;

  typedef struct packed {
    logic [DUTY_W-1:0] lf;
    logic [DUTY_W-1:0] lr;
    logic [DUTY_W-1:0] rf;
    logic [DUTY_W-1:0] rr;
  } duty_set_t;

  typedef struct packed {
    duty_set_t  duties;
    logic [3:0] lights;
  } cmd_decode_t;

  typedef struct packed {
    logic [DUTY_W-1:0] counter;
    logic [3:0]        motor;
  } pwm_state_t;

  localparam dir_entry_t DIR_TABLE [NUM_DIRS] = '{
    '{T_FULL,   T_ZERO,  T_FULL,   T_ZERO,  L_HEAD},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_FULL,  L_TAIL},
    '{T_FULL,   T_ZERO,  T_HALF,   T_ZERO,  L_HEAD | L_RIND},
    '{T_HALF,   T_ZERO,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_DOUBLE, T_ZERO,  T_THIRD,  T_ZERO,  L_HEAD | L_RIND},
    '{T_THIRD,  T_ZERO,  T_DOUBLE, T_ZERO,  L_HEAD | L_LIND},
    '{T_FULL,   T_ZERO,  T_FIFTH,  T_ZERO,  L_HEAD | L_RIND},
    '{T_FIFTH,  T_ZERO,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_FULL,   T_ZERO,  T_ZERO,   T_FULL,  L_HEAD | L_RIND},
    '{T_ZERO,   T_FULL,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_HALF,  L_TAIL | L_RIND},
    '{T_ZERO,   T_HALF,  T_ZERO,   T_FULL,  L_TAIL | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_THIRD, L_TAIL | L_RIND},
    '{T_ZERO,   T_THIRD, T_ZERO,   T_FULL,  L_TAIL | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_FIFTH, L_TAIL | L_RIND},
    '{T_ZERO,   T_FIFTH, T_ZERO,   T_FULL,  L_TAIL | L_LIND}
  };

  // Reciprocal multiplies, exact for every 8-bit value.
  function automatic logic [DUTY_W-1:0] div3(input logic [DUTY_W-1:0] s);
    logic [16:0] p;
    p = {9'd0, s} * 17'd171;
    return p[16:9];
  endfunction

  function automatic logic [DUTY_W-1:0] div5(input logic [DUTY_W-1:0] s);
    logic [17:0] p;
    p = {10'd0, s} * 18'd205;
    return p[17:10];
  endfunction

  function automatic logic [DUTY_W-1:0] term(input term_sel_t sel,
                                             input logic [DUTY_W-1:0] s);
    logic [DUTY_W-1:0] r;
    case (sel)
      T_FULL:   r = s;
      T_HALF:   r = {1'b0, s[DUTY_W-1:1]};
      T_THIRD:  r = div3(s);
      T_FIFTH:  r = div5(s);
      T_DOUBLE: r = {s[DUTY_W-2:0], 1'b0};
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/dtfc_cmd_decode.sv @@
// Drive command decoder: direction code and speed to four duties and lights.
`timescale 1ns / 1ps
`default_nettype none

module dtfc_cmd_decode
  import dtfc_pkg::*;
(
  input  wire logic [DUTY_W-1:0] speed,
  input  wire logic [DIR_W-1:0]  direction,
  output cmd_decode_t            cmd
);

  dir_entry_t entry;

  always_comb begin
    entry = DIR_TABLE[direction[3:0]];
    if (direction < DIR_W'(NUM_DIRS)) begin
      cmd.duties.lf = term(entry.lf, speed);
      cmd.duties.lr = term(entry.lr, speed);
      cmd.duties.rf = term(entry.rf, speed);
      cmd.duties.rr = term(entry.rr, speed);
      cmd.lights    = entry.lights;
    end else begin
      // Stationary keeps both indicators lit; any other code goes dark.
      cmd.duties = '0;
      cmd.lights = (direction == DIR_STATIONARY) ? (L_RIND | L_LIND) : L_NONE;
    end
  end

endmodule

`default_nettype wire

@@ src/dtfc_pwm_tick.sv @@
// PWM tick logic: pin toggles on duty match, period restart at the top value.
`timescale 1ns / 1ps
`default_nettype none

module dtfc_pwm_tick
  import dtfc_pkg::*;
(
  input  wire pwm_state_t        cur,
  input  wire duty_set_t         duties,
  input  wire logic [DUTY_W-1:0] period_top,
  output pwm_state_t             nxt
);

  logic [3:0] toggle;

  always_comb begin
    toggle[0] = (cur.counter == duties.lf);
    toggle[1] = (cur.counter == duties.lr);
    toggle[2] = (cur.counter == duties.rf);
    toggle[3] = (cur.counter == duties.rr);
    if (cur.counter == period_top) begin
      nxt.motor   = 4'hF;
      nxt.counter = '0;
    end else begin
      nxt.motor   = cur.motor ^ toggle;
      nxt.counter = cur.counter + DUTY_W'(1);
    end
  end

endmodule

`default_nettype wire

@@ src/direction_to_four_channel_pwm.sv @@
// Top level of the four-channel PWM differential drive with light control.
// Usage:
//   The input channel (in_valid/in_ready) carries one beat per PWM tick
//   (in_kind = 0) or per drive command (in_kind = 1, with in_speed and
//   in_direction). Every input beat yields exactly one result beat on the
//   output channel (out_valid/out_ready): the four motor pin levels and the
//   four light levels after that beat has been applied.
//   The cfg_wr_en/cfg_wr_data port writes period_top; the user must write it
//   only while no beat is in flight, as the block itself does not enforce this.
//
// Pipeline and throughput:
//   A beat is captured in an input register; when it advances, the tick or
//   command logic updates the drive state and loads the result register,
//   which raises out_valid. One beat per cycle is sustained while out_ready
//   stays high; the rate is set by the single state update stage.
//
// Reset and stall:
//   Synchronous active-low reset clears the counter, duties, pins and lights
//   and sets period_top to 100. When the receiver stalls, the result register
//   holds its beat, the input register holds one more, and in_ready drops.

`timescale 1ns / 1ps
`default_nettype none

module direction_to_four_channel_pwm
  import dtfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_wr_en,
  input  wire logic [DUTY_W-1:0] cfg_wr_data,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_kind,
  input  wire logic [DUTY_W-1:0] in_speed,
  input  wire logic [DIR_W-1:0]  in_direction,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_left_fwd_pin,
  output logic                   out_left_rev_pin,
  output logic                   out_right_fwd_pin,
  output logic                   out_right_rev_pin,
  output logic                   out_head_light,
  output logic                   out_tail_light,
  output logic                   out_right_indicator,
  output logic                   out_left_indicator
);

  // Input register stage.
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [DUTY_W-1:0] s1_speed_r;
  logic [DIR_W-1:0]  s1_dir_r;

  // Drive state.
  logic [DUTY_W-1:0] period_top_r;
  logic [DUTY_W-1:0] counter_r, counter_nxt;
  duty_set_t         duties_r, duties_nxt;
  logic [3:0]        motor_r, motor_nxt;
  logic [3:0]        lights_r, lights_nxt;

  // Result register.
  logic       out_valid_r;
  logic [3:0] out_motor_r;
  logic [3:0] out_lights_r;

  logic        out_load;
  logic        s1_fire;
  logic        in_fire;
  cmd_decode_t cmd;
  pwm_state_t  pwm_cur, pwm_nxt;

  // The result register takes a new beat when it is empty or being drained;
  // the input register then advances in the same cycle.
  assign out_load = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;

  dtfc_cmd_decode u_cmd_decode (
    .speed     (s1_speed_r),
    .direction (s1_dir_r),
    .cmd       (cmd)
  );

  assign pwm_cur.counter = counter_r;
  assign pwm_cur.motor   = motor_r;

  dtfc_pwm_tick u_pwm_tick (
    .cur        (pwm_cur),
    .duties     (duties_r),
    .period_top (period_top_r),
    .nxt        (pwm_nxt)
  );

  // A tick moves the counter and pins; a command reloads duties and lights.
  always_comb begin
    counter_nxt = counter_r;
    motor_nxt   = motor_r;
    duties_nxt  = duties_r;
    lights_nxt  = lights_r;
    if (s1_kind_r == KIND_TICK) begin
      counter_nxt = pwm_nxt.counter;
      motor_nxt   = pwm_nxt.motor;
    end else begin
      duties_nxt = cmd.duties;
      lights_nxt = cmd.lights;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      period_top_r <= PERIOD_TOP_RESET;
      counter_r    <= '0;
      duties_r     <= '0;
      motor_r      <= '0;
      lights_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_top_r <= cfg_wr_data;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        counter_r <= counter_nxt;
        duties_r  <= duties_nxt;
        motor_r   <= motor_nxt;
        lights_r  <= lights_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r  <= in_kind;
      s1_speed_r <= in_speed;
      s1_dir_r   <= in_direction;
    end
    if (s1_fire) begin
      out_motor_r  <= motor_nxt;
      out_lights_r <= lights_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_fwd_pin    = out_motor_r[0];
  assign out_left_rev_pin    = out_motor_r[1];
  assign out_right_fwd_pin   = out_motor_r[2];
  assign out_right_rev_pin   = out_motor_r[3];
  assign out_head_light      = out_lights_r[0];
  assign out_tail_light      = out_lights_r[1];
  assign out_right_indicator = out_lights_r[2];
  assign out_left_indicator  = out_lights_r[3];

  // A tick at the period top forces every motor pin high and restarts.
  a_period_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_kind_r == KIND_TICK) && (counter_r == period_top_r)
    |=> (motor_r == 4'hF) && (counter_r == '0))
    else $error("period top did not restart the counter and set the pins");

  // A command never disturbs the counter or the motor pins.
  a_cmd_keeps_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_kind_r == KIND_COMMAND)
    |=> $stable(counter_r) && $stable(motor_r))
    else $error("command changed the PWM counter or pins");

  // The stationary code lights both indicators and zeroes the duties.
  a_stationary: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (s1_kind_r == KIND_COMMAND) && (s1_dir_r == DIR_STATIONARY)
    |=> (lights_r == (L_RIND | L_LIND)) && (duties_r == '0))
    else $error("stationary command gave wrong lights or duties");

  // Back-pressure reaches the input only when both stages are occupied.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room in the pipeline");

  // A result beat follows the input stage that produced it.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("input stage advanced without loading a result");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the four-channel PWM drive, with directed and random beats.
`timescale 1ns / 1ps

module testbench;
  import dtfc_pkg::*;

  // The watchdog ends the run after this many cycles in which neither channel
  // moves a beat. The longest legitimate quiet stretch is the long receiver
  // hold-off below, plus a long sender gap, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RX_HOLD_CYCLES = 150;
  localparam int unsigned RANDOM_BLOCKS  = 11;
  localparam int unsigned BLOCK_BEATS    = 72;
  localparam int unsigned MAX_REPORTS    = 10;

  // One result beat as it appears on the output ports.
  typedef struct packed {
    logic left_fwd;
    logic left_rev;
    logic right_fwd;
    logic right_rev;
    logic head;
    logic tail;
    logic right_ind;
    logic left_ind;
  } drive_levels_t;

  // Our own copy of the steering map: which fraction of the speed goes to each
  // duty, and which lights come on, for direction codes 0 through 15.
  localparam dir_entry_t STEER_MAP [NUM_DIRS] = '{
    '{T_FULL,   T_ZERO,  T_FULL,   T_ZERO,  L_HEAD},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_FULL,  L_TAIL},
    '{T_FULL,   T_ZERO,  T_HALF,   T_ZERO,  L_HEAD | L_RIND},
    '{T_HALF,   T_ZERO,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_DOUBLE, T_ZERO,  T_THIRD,  T_ZERO,  L_HEAD | L_RIND},
    '{T_THIRD,  T_ZERO,  T_DOUBLE, T_ZERO,  L_HEAD | L_LIND},
    '{T_FULL,   T_ZERO,  T_FIFTH,  T_ZERO,  L_HEAD | L_RIND},
    '{T_FIFTH,  T_ZERO,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_FULL,   T_ZERO,  T_ZERO,   T_FULL,  L_HEAD | L_RIND},
    '{T_ZERO,   T_FULL,  T_FULL,   T_ZERO,  L_HEAD | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_HALF,  L_TAIL | L_RIND},
    '{T_ZERO,   T_HALF,  T_ZERO,   T_FULL,  L_TAIL | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_THIRD, L_TAIL | L_RIND},
    '{T_ZERO,   T_THIRD, T_ZERO,   T_FULL,  L_TAIL | L_LIND},
    '{T_ZERO,   T_FULL,  T_ZERO,   T_FIFTH, L_TAIL | L_RIND},
    '{T_ZERO,   T_FIFTH, T_ZERO,   T_FULL,  L_TAIL | L_LIND}
  };

  // Every input of the block has a known value from time zero.
  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic [DUTY_W-1:0] cfg_wr_data  = '0;
  logic              in_valid     = 1'b0;
  logic              in_kind      = KIND_TICK;
  logic [DUTY_W-1:0] in_speed     = '0;
  logic [DIR_W-1:0]  in_direction = '0;
  logic              out_ready    = 1'b0;

  logic in_ready;
  logic out_valid;
  logic out_left_fwd_pin;
  logic out_left_rev_pin;
  logic out_right_fwd_pin;
  logic out_right_rev_pin;
  logic out_head_light;
  logic out_tail_light;
  logic out_right_indicator;
  logic out_left_indicator;

  // Predicted drive state, kept in step with every accepted input beat.
  logic [DUTY_W-1:0] period_now;
  logic [DUTY_W-1:0] pwm_count;
  duty_set_t         duty_now;
  logic [3:0]        motor_now;
  logic [3:0]        lights_now;

  // Result beats still owed by the block, oldest first.
  drive_levels_t levels_q[$];

  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait      = 0;
  int unsigned rx_hold_req  = 0;
  bit          tx_idle_en   = 1'b1;
  bit          rx_idle_en   = 1'b1;

  direction_to_four_channel_pwm u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_speed            (in_speed),
    .in_direction        (in_direction),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_left_fwd_pin    (out_left_fwd_pin),
    .out_left_rev_pin    (out_left_rev_pin),
    .out_right_fwd_pin   (out_right_fwd_pin),
    .out_right_rev_pin   (out_right_rev_pin),
    .out_head_light      (out_head_light),
    .out_tail_light      (out_tail_light),
    .out_right_indicator (out_right_indicator),
    .out_left_indicator  (out_left_indicator)
  );

  // 10 ns clock period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle gap length for either side: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap(input bit enable);
    int unsigned r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void reset_drive_model();
    period_now = PERIOD_TOP_RESET;
    pwm_count  = '0;
    duty_now   = '0;
    motor_now  = '0;
    lights_now = L_NONE;
  endfunction

  // One duty value from the speed. Doubling drops the carry, so speeds of 128
  // and above wrap around.
  function automatic logic [DUTY_W-1:0] scaled_duty(input term_sel_t sel,
                                                    input logic [DUTY_W-1:0] s);
    case (sel)
      T_FULL:   return s;
      T_HALF:   return s / 8'd2;
      T_THIRD:  return s / 8'd3;
      T_FIFTH:  return s / 8'd5;
      T_DOUBLE: return DUTY_W'(s * 2);
      default:  return '0;
    endcase
  endfunction

  // Advances the predicted state by one accepted beat and returns the levels
  // that the block has to show for it.
  function automatic drive_levels_t apply_beat(input logic kind,
                                               input logic [DUTY_W-1:0] speed,
                                               input logic [DIR_W-1:0] dir);
    dir_entry_t    e;
    drive_levels_t r;
    if (kind == KIND_TICK) begin
      // Each pin flips when the counter meets its duty. Several pins can flip
      // on the same tick, and the set-high at the top of the period wins.
      if (pwm_count == duty_now.lf) motor_now[0] = ~motor_now[0];
      if (pwm_count == duty_now.lr) motor_now[1] = ~motor_now[1];
      if (pwm_count == duty_now.rf) motor_now[2] = ~motor_now[2];
      if (pwm_count == duty_now.rr) motor_now[3] = ~motor_now[3];
      if (pwm_count == period_now) begin
        motor_now = '1;
        pwm_count = '0;
      end else begin
        // A counter left above a lowered top runs on and wraps past 255.
        pwm_count = pwm_count + 1'b1;
      end
    end else if (dir < NUM_DIRS) begin
      e = STEER_MAP[dir[3:0]];
      duty_now.lf = scaled_duty(e.lf, speed);
      duty_now.lr = scaled_duty(e.lr, speed);
      duty_now.rf = scaled_duty(e.rf, speed);
      duty_now.rr = scaled_duty(e.rr, speed);
      lights_now  = e.lights;
    end else begin
      // Stationary lights both indicators; any other unknown code goes dark.
      duty_now   = '0;
      lights_now = (dir == DIR_STATIONARY) ? (L_RIND | L_LIND) : L_NONE;
    end
    r.left_fwd  = motor_now[0];
    r.left_rev  = motor_now[1];
    r.right_fwd = motor_now[2];
    r.right_rev = motor_now[3];
    r.head      = lights_now[0];
    r.tail      = lights_now[1];
    r.right_ind = lights_now[2];
    r.left_ind  = lights_now[3];
    return r;
  endfunction

  task automatic log_fault(input string why, input drive_levels_t want,
                           input drive_levels_t got);
    if (fault_count < MAX_REPORTS) begin
      $display("%0t: %s (LF LR RF RR HD TL RI LI) expected %b actual %b",
               $time, why, want, got);
    end
    fault_count++;
  endtask

  // Scoreboard. The predictor runs on each accepted input beat, before the
  // check of the same edge, so even a result shown at its accepting edge finds its entry.
  // All ports are read at the edge, before any update the edge causes.
  always @(posedge clk) begin : scoreboard
    drive_levels_t got;
    if (rst_n && in_valid && in_ready) begin
      levels_q.push_back(apply_beat(in_kind, in_speed, in_direction));
    end
    if (rst_n && out_valid && out_ready) begin
      got.left_fwd  = out_left_fwd_pin;
      got.left_rev  = out_left_rev_pin;
      got.right_fwd = out_right_fwd_pin;
      got.right_rev = out_right_rev_pin;
      got.head      = out_head_light;
      got.tail      = out_tail_light;
      got.right_ind = out_right_indicator;
      got.left_ind  = out_left_indicator;
      if (levels_q.size() == 0) begin
        log_fault("result beat with nothing expected", '0, got);
      end else if (got !== levels_q[0]) begin
        log_fault("result beat mismatch", levels_q[0], got);
        void'(levels_q.pop_front());
      end else begin
        void'(levels_q.pop_front());
      end
    end
  end

  // Receiver. It stalls for random gaps when idling is enabled, and a test can
  // ask for one long hold-off, which is counted down here cycle by cycle.
  always @(posedge clk) begin : receiver
    if (rx_hold_req != 0) begin
      rx_wait     = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
      rx_wait = pick_gap(rx_idle_en);
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[direction_to_four_channel_pwm] ERROR");
      $finish;
    end
  end

  // Offers one input beat and returns at the edge where it is accepted. The
  // valid stays high afterwards so that a following beat can go back to back;
  // it is lowered only when a gap is taken or the sender stops.
  task automatic send_beat(input logic kind, input logic [DUTY_W-1:0] speed,
                           input logic [DIR_W-1:0] dir);
    int unsigned gap;
    gap = pick_gap(tx_idle_en);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_speed     <= speed;
    in_direction <= dir;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_ticks(input int unsigned count);
    repeat (count) send_beat(KIND_TICK, 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
  endtask

  // Stops the sender and waits until every owed result has come back, then
  // lets the two-stage pipeline settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (levels_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes the period top while the block is idle.
  task automatic write_period(input logic [DUTY_W-1:0] top);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= top;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    period_now  = top;
  endtask

  // Directed: the first tick after reset (all duties zero, so every pin flips),
  // every direction code at full and wrapping speeds, the stationary code,
  // unknown codes on both sides of it, zero speed, and ticks whose speed and
  // direction are set but must be ignored.
  task automatic test_directed();
    int unsigned d;
    send_beat(KIND_TICK, 8'hFF, 8'hFF);
    for (d = 0; d < NUM_DIRS; d++) begin
      send_beat(KIND_COMMAND, (d == 5) ? 8'd128 : 8'hFF, DIR_W'(d));
    end
    send_beat(KIND_COMMAND, 8'hAA, DIR_STATIONARY);
    send_beat(KIND_COMMAND, 8'h55, DIR_W'(NUM_DIRS));
    send_beat(KIND_COMMAND, 8'hAA, DIR_STATIONARY - 1'b1);
    send_beat(KIND_COMMAND, 8'h55, DIR_STATIONARY + 1'b1);
    send_beat(KIND_COMMAND, 8'hFF, 8'hFF);
    send_beat(KIND_COMMAND, 8'h00, 8'h00);
    send_beat(KIND_TICK, 8'h00, 8'h00);
    send_beat(KIND_TICK, 8'hFF, DIR_STATIONARY);
  endtask

  // A period top of 1 and the largest period top, with duties at, below and above the
  // top, and equal duties that flip together on the same tick.
  task automatic test_period_extremes();
    write_period(8'd1);
    send_beat(KIND_COMMAND, 8'd2, 8'd2);
    send_ticks(6);
    send_beat(KIND_COMMAND, 8'd0, 8'd0);
    send_ticks(4);
    write_period(8'd255);
    send_beat(KIND_COMMAND, 8'd200, 8'd4);
    send_ticks(520);
  endtask

  // The top is lowered below the running counter, which must then run on past
  // 255, wrap to zero and meet the new top on the next pass.
  task automatic test_counter_overrun();
    write_period(8'd255);
    send_beat(KIND_COMMAND, 8'd60, 8'd8);
    send_ticks(200);
    write_period(8'd5);
    send_ticks(70);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // beats back to back, so the block fills up and drops in_ready. The sender
  // then pauses until every result has come back.
  task automatic test_stall_fill();
    int unsigned k;
    tx_idle_en  = 1'b0;
    rx_hold_req = RX_HOLD_CYCLES;
    for (k = 0; k < 24; k++) begin
      send_beat((k % 5 == 0) ? KIND_COMMAND : KIND_TICK,
                8'($urandom_range(0, 12)), 8'($urandom_range(0, 15)));
    end
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  // Random traffic in blocks, each with its own period top and idling mix.
  // Most beats are ticks. Speeds mostly stay near the top so that duties are
  // actually met by the counter; a few are pinned to the extremes.
  task automatic test_random_traffic();
    int unsigned       blk;
    int unsigned       k;
    int unsigned       r;
    int unsigned       speed_cap;
    logic [DUTY_W-1:0] top;
    logic [DUTY_W-1:0] spd;
    logic [DIR_W-1:0]  dir;
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk == 0) begin
        top = 8'd1;
      end else if (blk == 1) begin
        top = 8'd255;
      end else if ($urandom_range(0, 9) < 7) begin
        top = 8'($urandom_range(2, 24));
      end else begin
        top = 8'($urandom_range(25, 254));
      end
      write_period(top);
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      speed_cap  = 2 * top + 2;
      if (speed_cap > 255) speed_cap = 255;
      for (k = 0; k < BLOCK_BEATS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_ticks(1);
        end else begin
          case ($urandom_range(0, 9))
            0:       spd = 8'h00;
            1:       spd = 8'hFF;
            2:       spd = 8'($urandom_range(128, 255));
            default: spd = 8'($urandom_range(0, speed_cap));
          endcase
          r = $urandom_range(0, 99);
          if (r < 55) begin
            dir = 8'($urandom_range(0, NUM_DIRS - 1));
          end else if (r < 70) begin
            dir = DIR_STATIONARY;
          end else begin
            dir = 8'($urandom_range(0, 255));
          end
          send_beat(KIND_COMMAND, spd, dir);
        end
      end
    end
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    reset_drive_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_period_extremes();
    test_counter_overrun();
    test_stall_fill();
    test_random_traffic();

    // Let any stray result beat show up before the verdict.
    drain_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0 && levels_q.size() == 0) begin
      $display("[direction_to_four_channel_pwm] OK");
    end else begin
      $display("[direction_to_four_channel_pwm] ERROR");
    end
    $finish;
  end

endmodule
